@@ src/fpa_pkg.sv @@
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    // dividend magnitude shifted by the fraction bits
    localparam int DVD_W     = WORD_W + FRAC_BITS;
    // one divider cell per quotient bit
    localparam int QUO_W     = DVD_W;
    // remainder needs one bit above the 32-bit divisor magnitude
    localparam int REM_W     = WORD_W + 1;
    // depth of the cell chain: one cell per quotient bit plus entry and exit stages
    localparam int LAT       = QUO_W + 2;

    localparam logic signed [WORD_W-1:0] MAX_W = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] MIN_W = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    // finished result of the simple ops, carried alongside the divider
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              cond;
        logic              dz;
        logic              ovf;
    } res_t;

    // everything a cell hands to its neighbor
    typedef struct packed {
        logic              vld;
        logic              is_div;
        logic              neg;
        logic [DVD_W-1:0]  dvd;
        logic [REM_W-1:0]  rem;
        logic [WORD_W-1:0] dvs;
        logic [QUO_W-1:0]  quo;
        res_t              res;
    } cell_t;

    // saturate a wide signed value to the word range
    function automatic res_t sat_res(input logic signed [65:0] v);
        res_t r;
        r = '0;
        if (v > 66'(signed'(MAX_W))) begin
            r.word = MAX_W;
            r.ovf  = 1'b1;
        end else if (v < 66'(signed'(MIN_W))) begin
            r.word = MIN_W;
            r.ovf  = 1'b1;
        end else begin
            r.word = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/fpa_front.sv @@
module fpa_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [3:0]                   cmd,
    input  logic signed [31:0]           op_a,
    input  logic signed [31:0]           op_b,
    output fpa_pkg::cell_t               cell_out
);
    import fpa_pkg::*;

    cell_t             cell_reg, cell_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               mul_reg, mul_next;
    res_t               res;
    logic [WORD_W-1:0]  mag_a, mag_b;
    logic signed [65:0] a66, b66;

    // one register stage: simple ops finish here, mul forms its product
    always_comb begin
        a66   = 66'(op_a);
        b66   = 66'(op_b);
        mag_a = op_a[31] ? WORD_W'(-op_a) : WORD_W'(op_a);
        mag_b = op_b[31] ? WORD_W'(-op_b) : WORD_W'(op_b);
        res   = '0;
        unique case (op_t'(cmd))
            OP_ADD:     res = sat_res(a66 + b66);
            OP_SUB:     res = sat_res(a66 - b66);
            OP_MUL:     res = '0;
            OP_DIV: begin
                if (op_b == '0) begin
                    res.dz   = 1'b1;
                    res.word = op_a[31] ? MIN_W : ((op_a == '0) ? '0 : MAX_W);
                end
            end
            OP_GT:      res.cond = op_a > op_b;
            OP_LT:      res.cond = op_a < op_b;
            OP_GE:      res.cond = op_a >= op_b;
            OP_LE:      res.cond = op_a <= op_b;
            OP_EQ:      res.cond = op_a == op_b;
            OP_NE:      res.cond = op_a != op_b;
            OP_MIN:     res.word = (op_a < op_b) ? op_a : op_b;
            OP_MAX:     res.word = (op_a > op_b) ? op_a : op_b;
            OP_INC:     res = sat_res(a66 + 66'sd1);
            OP_DEC:     res = sat_res(a66 - 66'sd1);
            OP_TOINT:   res.word = WORD_W'(op_a >>> FRAC_BITS);
            OP_FROMINT: res = sat_res(a66 <<< FRAC_BITS);
            default:    res = '0;
        endcase
        cell_next        = '0;
        cell_next.vld    = in_vld;
        cell_next.is_div = (op_t'(cmd) == OP_DIV) && (op_b != '0);
        cell_next.neg    = op_a[31] ^ op_b[31];
        cell_next.dvd    = {mag_a, {FRAC_BITS{1'b0}}};
        cell_next.dvs    = mag_b;
        cell_next.res    = res;
        mul_next         = (op_t'(cmd) == OP_MUL);
        prod_next        = op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg.vld <= cell_next.vld;
        end
        if (en) begin
            cell_reg.is_div <= cell_next.is_div;
            cell_reg.neg    <= cell_next.neg;
            cell_reg.dvd    <= cell_next.dvd;
            cell_reg.rem    <= cell_next.rem;
            cell_reg.dvs    <= cell_next.dvs;
            cell_reg.quo    <= cell_next.quo;
            cell_reg.res    <= cell_next.res;
            prod_reg        <= prod_next;
            mul_reg         <= mul_next;
        end
    end

    // rounding of the registered product, ties away from zero
    logic [63:0]        pmag;
    logic [64:0]        prnd;
    logic signed [65:0] pval;
    always_comb begin
        pmag     = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        prnd     = (65'(pmag) + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        pval     = prod_reg[63] ? -66'(signed'({1'b0, prnd})) : 66'(signed'({1'b0, prnd}));
        cell_out = cell_reg;
        if (mul_reg) begin
            cell_out.res = sat_res(pval);
        end
    end

endmodule

@@ src/fpa_cell.sv @@
module fpa_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  fpa_pkg::cell_t cin,
    output fpa_pkg::cell_t cout
);
    import fpa_pkg::*;

    cell_t                cell_reg, cell_next;
    logic [REM_W:0]       trial;
    logic [REM_W-1:0]     shifted;

    // one restoring step: shift in the next dividend bit, try a subtract
    always_comb begin
        cell_next = cin;
        shifted   = {cin.rem[REM_W-2:0], cin.dvd[DVD_W-1]};
        trial     = {1'b0, shifted} - {2'b0, cin.dvs};
        cell_next.dvd = {cin.dvd[DVD_W-2:0], 1'b0};
        if (!trial[REM_W]) begin
            cell_next.rem = trial[REM_W-1:0];
            cell_next.quo = {cin.quo[QUO_W-2:0], 1'b1};
        end else begin
            cell_next.rem = shifted;
            cell_next.quo = {cin.quo[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg.vld <= cell_next.vld;
        end
        if (en) begin
            cell_reg.is_div <= cell_next.is_div;
            cell_reg.neg    <= cell_next.neg;
            cell_reg.dvd    <= cell_next.dvd;
            cell_reg.rem    <= cell_next.rem;
            cell_reg.dvs    <= cell_next.dvs;
            cell_reg.quo    <= cell_next.quo;
            cell_reg.res    <= cell_next.res;
        end
    end

    assign cout = cell_reg;

endmodule

@@ src/fixed_point_alu.sv @@
// fixed-point alu, signed 32-bit words with FRAC_BITS fraction bits
//
// input channel s_*: cmd, operand_a, operand_b, one beat per item.
// result channel m_*: result_word plus condition, div_zero and overflow flags,
// exactly one result beat per input beat, in order.
//
// every item runs through the same chain: an entry stage (simple ops and the
// product), one divider cell per quotient bit (40 cells), and an exit stage
// that rounds, saturates and selects; every op takes this same path, and a
// new item may enter every cycle while the chain is not frozen, so throughput
// is then one item per cycle. the divider chain length sets the latency.
//
// the whole chain advances together; when m_ready is low while a result is
// waiting, the chain freezes and s_ready drops, and it resumes without loss.
// s_ready is high whenever the output slot is empty or being taken.
// reset (aresetn low, synchronous) empties the chain; no items are lost
// other than those in flight at reset.
module fixed_point_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_cmd,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_word,
    output logic               m_condition,
    output logic               m_div_zero,
    output logic               m_overflow
);
    import fpa_pkg::*;

    logic  en;
    cell_t chain [QUO_W+1];

    // chain advances unless the output holds a beat that is not taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    fpa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .cmd      (s_cmd),
        .op_a     (s_operand_a),
        .op_b     (s_operand_b),
        .cell_out (chain[0])
    );

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        fpa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .cin     (chain[i]),
            .cout    (chain[i+1])
        );
    end

    // exit stage: round the quotient and pick the result
    cell_t              last;
    logic [REM_W:0]     rem2;
    logic [QUO_W:0]     qrnd;
    logic signed [65:0] qval;
    res_t               res_next, res_reg;
    logic               vld_reg;

    always_comb begin
        last = chain[QUO_W];
        rem2 = {last.rem, 1'b0};
        // round half away: bump when twice the remainder reaches the divisor
        qrnd = {1'b0, last.quo} + (QUO_W+1)'(rem2 >= (REM_W+1)'(last.dvs));
        qval = last.neg ? -66'(signed'({1'b0, qrnd})) : 66'(signed'({1'b0, qrnd}));
        res_next = last.is_div ? sat_res(qval) : last.res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= last.vld;
        end
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = vld_reg;
    assign m_result_word = res_reg.word;
    assign m_condition   = res_reg.cond;
    assign m_div_zero    = res_reg.dz;
    assign m_overflow    = res_reg.ovf;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_word))
        else $error("result changed while stalled");

    // divide by zero never reports overflow
    a_dz_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_div_zero && m_overflow))
        else $error("div_zero with overflow");

    // a compare result carries a zero word
    a_cond_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_condition |-> m_result_word == '0)
        else $error("compare with nonzero word");

    // input is taken only when the chain moves
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("ready during stall");

endmodule
